/* design/sacf_pkg.sv */
package sacf_pkg;

  // fixed field widths
  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 32;
  localparam int OUTCOME_W = 2;
  localparam int WAY_OUT_W = 4;
  localparam int SET_OUT_W = 6;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 48;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BLK_LG = 2'd0,
    REG_SET_LG = 2'd1,
    REG_WAY_LG = 2'd2
  } cfg_reg_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

endpackage

/* design/sacf_ram.sv */
module sacf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/set_assoc_cache_fifo_lookup_core.sv */
// set-associative tag lookup with fifo replacement, one memory row per set
// the set row of an accepted item is read from the ram; in ST_LOOK, once the output register
// is free, the result is registered and the row written back; a new item is taken only in ST_IDLE
// reset (and a write to any of the three configuration registers) starts a clearing pass
// that zeroes every row; no item is accepted until it completes
// rst_n is synchronous, active low; config resets to block 2^3, 2^2 sets, 2^1 ways
module set_assoc_cache_fifo_lookup_core #(
  parameter int MAX_SETS  = 64,
  parameter int MAX_WAYS  = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_wen,
  input  logic [sacf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sacf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input items
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sacf_pkg::IN_DATA_W-1:0]      in_tdata,   // address[31:0]
  // result items
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [sacf_pkg::OUT_DATA_W-1:0]     out_tdata   // outcome[1:0], way_used[5:2],
                                                          // set_index[11:6], address_tag[43:12],
                                                          // zero[47:44]
);

  localparam int TAG_W      = sacf_pkg::TAG_W;
  localparam int ADDR_W     = sacf_pkg::ADDR_W;
  localparam int RA_W       = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SET_LG_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int WAY_LG_MAX = $clog2(MAX_WAYS + 1) - 1;
  localparam int WAY_AW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int VLD_LSB    = MAX_WAYS * TAG_W;
  localparam int ROW_W      = VLD_LSB + MAX_WAYS + WAY_AW;
  localparam int AM_W       = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - AM_W);

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t state_r;

  // configuration registers
  logic [3:0] blk_lg_r;
  logic [2:0] set_lg_r;
  logic [2:0] way_lg_r;

  // clearing pass
  logic            clr_active_r;
  logic [RA_W-1:0] clr_idx_r;

  // item in flight
  logic [RA_W-1:0]  set_r;
  logic [TAG_W-1:0] tag_r;

  // output register
  logic                           out_tvalid_r;
  logic [sacf_pkg::OUTCOME_W-1:0] out_outcome_r;
  logic [sacf_pkg::WAY_OUT_W-1:0] out_way_r;
  logic [sacf_pkg::SET_OUT_W-1:0] out_set_r;
  logic [TAG_W-1:0]               out_tag_r;

  // clamped geometry
  logic [2:0] sb;
  logic [2:0] wb;
  logic [WAY_AW-1:0] wmask;

  assign sb = (int'(set_lg_r) > SET_LG_MAX) ? 3'(SET_LG_MAX) : set_lg_r;
  assign wb = (int'(way_lg_r) > WAY_LG_MAX) ? 3'(WAY_LG_MAX) : way_lg_r;
  assign wmask = WAY_AW'((32'd1 << wb) - 32'd1);

  // address split
  logic [ADDR_W-1:0] blk_c;
  logic [RA_W-1:0]   set_c;
  logic [TAG_W-1:0]  tag_c;

  assign blk_c = (in_tdata & ADDR_MASK) >> blk_lg_r;
  assign set_c = RA_W'(blk_c & ((32'd1 << sb) - 32'd1));
  assign tag_c = blk_c >> sb;

  logic in_acc;
  logic out_free;
  logic look_done;

  assign in_tready = (state_r == ST_IDLE) && !clr_active_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign look_done = (state_r == ST_LOOK) && out_free;

  // set row memory: {fifo pointer, valid bits, tags}
  logic [ROW_W-1:0] row_rd;
  logic [ROW_W-1:0] row_nxt;
  logic             ram_wen;
  logic [RA_W-1:0]  ram_waddr;
  logic [ROW_W-1:0] ram_wdata;

  assign ram_wen   = clr_active_r || look_done;
  assign ram_waddr = clr_active_r ? clr_idx_r : set_r;
  assign ram_wdata = clr_active_r ? '0 : row_nxt;

  sacf_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_SETS)
  ) u_row_ram (
    .clk    (clk),
    .wr_en  (ram_wen),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (in_acc),
    .rd_addr(set_c),
    .rd_data(row_rd)
  );

  // way search and row update
  logic [WAY_AW-1:0]   ptr;
  logic [MAX_WAYS-1:0] vld;
  logic                found;
  logic [WAY_AW-1:0]   sel;
  logic [WAY_AW-1:0]   way_c;
  sacf_pkg::outcome_t  outcome_c;

  always_comb begin
    ptr   = row_rd[ROW_W-1 -: WAY_AW];
    vld   = row_rd[VLD_LSB +: MAX_WAYS];
    found = 1'b0;
    sel   = '0;
    // walk downward so the lowest candidate way wins
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (((w >> wb) == 0) &&
          (!vld[w] || (row_rd[w*TAG_W +: TAG_W] == tag_r))) begin
        found = 1'b1;
        sel   = WAY_AW'(w);
      end
    end

    if (!found) begin
      outcome_c = sacf_pkg::OUT_EVICT;
      way_c     = ptr & wmask;
    end else if (vld[sel]) begin
      outcome_c = sacf_pkg::OUT_HIT;
      way_c     = sel;
    end else begin
      outcome_c = sacf_pkg::OUT_FILL;
      way_c     = sel;
    end

    row_nxt = row_rd;
    if (outcome_c != sacf_pkg::OUT_HIT) begin
      row_nxt[way_c*TAG_W +: TAG_W] = tag_r;
      row_nxt[VLD_LSB + way_c]      = 1'b1;
    end
    if (outcome_c == sacf_pkg::OUT_EVICT) begin
      row_nxt[ROW_W-1 -: WAY_AW] = (way_c + WAY_AW'(1)) & wmask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      blk_lg_r     <= 4'd3;
      set_lg_r     <= 3'd2;
      way_lg_r     <= 3'd1;
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // clearing sweep, restarted by a write to any of the three configuration registers
      if (cfg_wen && (cfg_addr == sacf_pkg::REG_BLK_LG ||
                      cfg_addr == sacf_pkg::REG_SET_LG ||
                      cfg_addr == sacf_pkg::REG_WAY_LG)) begin
        clr_active_r <= 1'b1;
        clr_idx_r    <= '0;
      end else if (clr_active_r) begin
        if (clr_idx_r == RA_W'(MAX_SETS - 1)) begin
          clr_active_r <= 1'b0;
        end
        clr_idx_r <= clr_idx_r + RA_W'(1);
      end

      if (cfg_wen) begin
        if (cfg_addr == sacf_pkg::REG_BLK_LG) begin
          blk_lg_r <= cfg_wdata;
        end
        if (cfg_addr == sacf_pkg::REG_SET_LG) begin
          set_lg_r <= cfg_wdata[2:0];
        end
        if (cfg_addr == sacf_pkg::REG_WAY_LG) begin
          way_lg_r <= cfg_wdata[2:0];
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (look_done) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end

    // payload registers
    if (in_acc) begin
      set_r <= set_c;
      tag_r <= tag_c;
    end
    if (look_done) begin
      out_outcome_r <= outcome_c;
      out_way_r     <= sacf_pkg::WAY_OUT_W'(way_c);
      out_set_r     <= sacf_pkg::SET_OUT_W'(set_r);
      out_tag_r     <= tag_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_tag_r, out_set_r, out_way_r, out_outcome_r};

endmodule

/* test/lookup_checker.sv */
`timescale 1ns / 1ps
module lookup_checker #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wen,
  input  logic [sacf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sacf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [sacf_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [sacf_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending
);

  localparam int SET_LG_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int WAY_LG_MAX = $clog2(MAX_WAYS + 1) - 1;

  typedef struct {
    sacf_pkg::outcome_t         outcome;
    logic [3:0]                 way;
    logic [5:0]                 set_idx;
    logic [sacf_pkg::TAG_W-1:0] tag;
  } lookup_t;

  lookup_t expected_lookups[$];
  lookup_t want;
  int      err_cnt = 0;

  // shadow of the tag store and its settings
  logic [sacf_pkg::TAG_W-1:0] tag_mem   [MAX_SETS][MAX_WAYS];
  logic                       valid_mem [MAX_SETS][MAX_WAYS];
  logic [3:0]                 fifo_ptr  [MAX_SETS];
  logic [3:0]                 blk_lg;
  logic [2:0]                 set_lg;
  logic [2:0]                 way_lg;

  task automatic clear_lines();
    for (int s = 0; s < MAX_SETS; s++) begin
      fifo_ptr[s] = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
        tag_mem[s][w]   = '0;
        valid_mem[s][w] = 1'b0;
      end
    end
  endtask

  function automatic lookup_t lookup_addr(input logic [sacf_pkg::ADDR_W-1:0] addr);
    lookup_t     r;
    logic [31:0] blk;
    int          sbits;
    int          wbits;
    int          nways;
    int          s;
    bit          done;
    sbits = (int'(set_lg) > SET_LG_MAX) ? SET_LG_MAX : int'(set_lg);
    wbits = (int'(way_lg) > WAY_LG_MAX) ? WAY_LG_MAX : int'(way_lg);
    nways = 1 << wbits;
    blk = addr >> blk_lg;
    r.set_idx = 6'(blk & ((32'd1 << sbits) - 32'd1));
    r.tag = blk >> sbits;
    r.outcome = sacf_pkg::OUT_EVICT;
    r.way = '0;
    s = r.set_idx;
    done = 1'b0;
    for (int w = 0; w < nways && !done; w++) begin
      if (valid_mem[s][w] && tag_mem[s][w] == r.tag) begin
        r.outcome = sacf_pkg::OUT_HIT;
        r.way = 4'(w);
        done = 1'b1;
      end else if (!valid_mem[s][w]) begin
        tag_mem[s][w] = r.tag;
        valid_mem[s][w] = 1'b1;
        r.outcome = sacf_pkg::OUT_FILL;
        r.way = 4'(w);
        done = 1'b1;
      end
    end
    if (!done) begin
      // set full: replace the oldest way and advance the pointer
      r.way = fifo_ptr[s] & 4'(nways - 1);
      tag_mem[s][r.way] = r.tag;
      fifo_ptr[s] = (r.way + 4'd1) & 4'(nways - 1);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      blk_lg = 4'd3;
      set_lg = 3'd2;
      way_lg = 3'd1;
      clear_lines();
      expected_lookups.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_lookups.size() == 0) begin
          $error("result item with no expectation waiting: %h", out_tdata);
          err_cnt++;
        end else begin
          want = expected_lookups.pop_front();
          if (out_tdata[1:0] !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, out_tdata[1:0]);
            err_cnt++;
          end
          if (out_tdata[5:2] !== want.way) begin
            $error("way_used: expected %0d, got %0d", want.way, out_tdata[5:2]);
            err_cnt++;
          end
          if (out_tdata[11:6] !== want.set_idx) begin
            $error("set_index: expected %0d, got %0d", want.set_idx, out_tdata[11:6]);
            err_cnt++;
          end
          if (out_tdata[43:12] !== want.tag) begin
            $error("address_tag: expected %h, got %h", want.tag, out_tdata[43:12]);
            err_cnt++;
          end
          if (out_tdata[47:44] !== 4'd0) begin
            $error("padding: expected 0, got %h", out_tdata[47:44]);
            err_cnt++;
          end
        end
      end
      if (cfg_wen) begin
        case (cfg_addr)
          sacf_pkg::REG_BLK_LG: begin
            blk_lg = cfg_wdata;
            clear_lines();
          end
          sacf_pkg::REG_SET_LG: begin
            set_lg = cfg_wdata[2:0];
            clear_lines();
          end
          sacf_pkg::REG_WAY_LG: begin
            way_lg = cfg_wdata[2:0];
            clear_lines();
          end
          default: ;  // unused index leaves everything alone
        endcase
      end
      if (in_tvalid && in_tready)
        expected_lookups.push_back(lookup_addr(in_tdata));
    end
    pending    <= expected_lookups.size();
    fail_count <= err_cnt;
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;

  localparam logic [sacf_pkg::CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
  localparam int POOL_SIZE = 32;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            cfg_wen    = 1'b0;
  logic [sacf_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [sacf_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [sacf_pkg::IN_DATA_W-1:0]  in_tdata   = '0;   // address[31:0]
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [sacf_pkg::OUT_DATA_W-1:0] out_tdata;         // outcome[1:0], way_used[5:2],
                                                      // set_index[11:6],
                                                      // address_tag[43:12], zero[47:44]
  int fail_count;
  int pending;

  int send_idle_pct = 32;
  int recv_idle_pct = 80;

  // current settings as seen by the address generator
  logic [3:0]  cur_blk   = 4'd3;
  int          cur_sbits = 2;
  int          cur_wbits = 1;
  logic [31:0] addr_pool [POOL_SIZE];
  int          pool_fill = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  set_assoc_cache_fifo_lookup_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  lookup_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send_addr(input logic [31:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= a;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop sending and let every expected result come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sacf_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [3:0] val);
    // hold off while a clearing pass is still running
    while (!in_tready) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    case (idx)
      sacf_pkg::REG_BLK_LG: cur_blk = val;
      sacf_pkg::REG_SET_LG: cur_sbits = (val[2:0] > 6) ? 6 : val[2:0];
      sacf_pkg::REG_WAY_LG: cur_wbits = (val[2:0] > 4) ? 4 : val[2:0];
      default: ;
    endcase
  endtask

  // mostly reuse of a few blocks in a few sets, so hits and evictions are common
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    logic [31:0] off_mask;
    logic [31:0] tag_v;
    logic [31:0] set_v;
    int          r;
    int          nsets;
    off_mask = (32'd1 << cur_blk) - 32'd1;
    nsets = 1 << cur_sbits;
    r = $urandom_range(99);
    if (r < 15) begin
      a = $urandom();
    end else if (r < 55 && pool_fill > 0) begin
      a = (addr_pool[$urandom_range(pool_fill - 1)] & ~off_mask) | ($urandom() & off_mask);
    end else begin
      tag_v = $urandom_range((2 << cur_wbits) + 1);
      if ($urandom_range(99) < 70)
        set_v = $urandom_range((nsets > 4) ? 3 : nsets - 1);
      else
        set_v = $urandom_range(nsets - 1);
      a = (tag_v << (cur_blk + cur_sbits)) | (set_v << cur_blk) | ($urandom() & off_mask);
    end
    if (pool_fill < POOL_SIZE) begin
      addr_pool[pool_fill] = a;
      pool_fill++;
    end else begin
      addr_pool[$urandom_range(POOL_SIZE - 1)] = a;
    end
    return a;
  endfunction

  initial begin
    logic [31:0] directed_addrs[$];
    logic [3:0]  b_lg;
    logic [3:0]  s_lg;
    logic [3:0]  w_lg;
    directed_addrs = '{32'h0000_0000, 32'h0000_0007, 32'h0000_0020, 32'h0000_0040,
                       32'h0000_0060, 32'h0000_0047, 32'h0000_0000, 32'hFFFF_FFFF,
                       32'hFFFF_FFF8, 32'h0000_0008, 32'h0000_0010, 32'h0000_0018,
                       32'hAAAA_AAAA, 32'h5555_5555};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 8-byte blocks, 4 sets, 2 ways
    foreach (directed_addrs[i]) send_addr(directed_addrs[i]);
    drain();
    // an index past the register list must not clear the lines
    write_reg(REG_SPARE, 4'hF);
    send_addr(32'h0000_0000);
    send_addr(32'h0000_0060);
    send_addr(32'hFFFF_FFFF);

    for (int p = 0; p < 10; p++) begin
      drain();
      case (p)
        0: begin b_lg = 4'd0;  s_lg = 4'd0;  w_lg = 4'd0;  end
        1: begin b_lg = 4'd8;  s_lg = 4'd6;  w_lg = 4'd4;  end
        2: begin b_lg = 4'd15; s_lg = 4'd15; w_lg = 4'd15; end
        3: begin b_lg = 4'd2;  s_lg = 4'd0;  w_lg = 4'd4;  end
        4: begin b_lg = 4'd4;  s_lg = 4'd7;  w_lg = 4'd0;  end
        default: begin
          b_lg = $urandom_range(6);
          s_lg = $urandom_range(15);
          w_lg = $urandom_range(15);
        end
      endcase
      if (p < 3) begin
        send_idle_pct = 32;
        recv_idle_pct = 80;
      end else if (p < 6) begin
        send_idle_pct = 80;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(sacf_pkg::REG_BLK_LG, b_lg);
      write_reg(sacf_pkg::REG_SET_LG, s_lg);
      write_reg(sacf_pkg::REG_WAY_LG, w_lg);
      repeat (50) send_addr(pick_addr());
    end

    drain();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
